/* hdl/swc_pkg.sv */
// swc_pkg: shared constants, widths, handshake structs and the arctangent table
// for the swept circle collision block; used by every module under hdl
`default_nettype none

package swc_pkg;

  // sweep limits and angle format
  localparam int MAX_SUBSTEPS = 64;
  localparam int ANGLE_BITS   = 12;
  localparam int PHASE_W      = 16;
  localparam logic [PHASE_W-1:0] ANGLE_MASK = PHASE_W'((1 << ANGLE_BITS) - 1);

  // field widths
  localparam int COORD_W = 16;
  localparam int LEN_W   = 12;
  localparam int RSUM_W  = LEN_W + 1;
  localparam int RR_W    = 2 * RSUM_W;

  // cordic datapath
  localparam int CORDIC_STEPS = 14;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W     = 20;
  localparam int ZANG_W       = 18;
  localparam int CORDIC_GAIN  = 39797;
  localparam int CORDIC_RND   = 2;
  localparam int CORDIC_DROP  = 2;
  localparam int Q14_W        = 16;
  localparam int Q14_ONE      = 16384;
  localparam int Q14_FRAC     = 14;
  localparam int Q14_HALF     = 8192;

  // shared multiplier and distance datapath
  localparam int POS_W  = 20;
  localparam int MUL_W  = POS_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 2 * POS_W + 1;
  localparam int CNT_W  = $clog2(MAX_SUBSTEPS + 1);
  localparam int ACC_W  = RSUM_W + 1;

  typedef struct packed {
    logic               start;
    logic [PHASE_W-1:0] phase;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [Q14_W-1:0] sin_q;
    logic signed [Q14_W-1:0] cos_q;
  } cordic_rsp_t;

  // arctangent of 2^-i, 16-bit phase units
  function automatic logic [ZANG_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ZANG_W-1:0] v;
    unique case (idx)
      4'd0:    v = ZANG_W'(8192);
      4'd1:    v = ZANG_W'(4836);
      4'd2:    v = ZANG_W'(2555);
      4'd3:    v = ZANG_W'(1297);
      4'd4:    v = ZANG_W'(651);
      4'd5:    v = ZANG_W'(326);
      4'd6:    v = ZANG_W'(163);
      4'd7:    v = ZANG_W'(81);
      4'd8:    v = ZANG_W'(41);
      4'd9:    v = ZANG_W'(20);
      4'd10:   v = ZANG_W'(10);
      4'd11:   v = ZANG_W'(5);
      4'd12:   v = ZANG_W'(3);
      4'd13:   v = ZANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/swc_cordic.sv */
// swc_cordic: iterative shift-add cordic, one rotation per cycle, gives Q1.14 sin/cos
// depends on swc_pkg
`default_nettype none

module swc_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swc_pkg::cordic_req_t req,
  output swc_pkg::cordic_rsp_t      rsp
);

  logic signed [swc_pkg::CORDIC_W-1:0] x_r, y_r, x_nxt, y_nxt, dx_s, dy_s;
  logic signed [swc_pkg::ZANG_W-1:0]   z_r, z_nxt, z_init;
  logic [swc_pkg::STEP_W-1:0]          i_r;
  logic                                busy_r, fin_r, flip_r;
  logic                                flip_in;
  logic [swc_pkg::PHASE_W-1:0]         ph_fold;
  logic signed [swc_pkg::CORDIC_W-1:0] xs, ys;
  logic signed [swc_pkg::Q14_W-1:0]    xc, yc;
  logic                                done_r;
  logic signed [swc_pkg::Q14_W-1:0]    sin_r, cos_r;

  function automatic logic signed [swc_pkg::Q14_W-1:0] clamp_q14(
    input logic signed [swc_pkg::CORDIC_W-1:0] v
  );
    logic signed [swc_pkg::CORDIC_W-1:0] hi, lo;
    logic signed [swc_pkg::Q14_W-1:0]    res;
    hi = swc_pkg::CORDIC_W'(swc_pkg::Q14_ONE);
    lo = -hi;
    if (v > hi) begin
      res = swc_pkg::Q14_W'(hi);
    end else if (v < lo) begin
      res = swc_pkg::Q14_W'(lo);
    end else begin
      res = swc_pkg::Q14_W'(v);
    end
    return res;
  endfunction

  // fold the 2nd and 3rd quadrants onto the 1st and 4th
  assign flip_in = req.phase[swc_pkg::PHASE_W-1] ^ req.phase[swc_pkg::PHASE_W-2];
  assign ph_fold = req.phase ^ {flip_in, {(swc_pkg::PHASE_W-1){1'b0}}};
  assign z_init  = swc_pkg::ZANG_W'($signed(ph_fold));

  assign dx_s = y_r >>> i_r;
  assign dy_s = x_r >>> i_r;

  always_comb begin
    if (!z_r[swc_pkg::ZANG_W-1]) begin
      x_nxt = x_r - dx_s;
      y_nxt = y_r + dy_s;
      z_nxt = z_r - $signed(swc_pkg::atan_lut(i_r));
    end else begin
      x_nxt = x_r + dx_s;
      y_nxt = y_r - dy_s;
      z_nxt = z_r + $signed(swc_pkg::atan_lut(i_r));
    end
  end

  // round Q.16 to Q1.14, half up
  assign xs = (x_r + swc_pkg::CORDIC_W'(swc_pkg::CORDIC_RND)) >>> swc_pkg::CORDIC_DROP;
  assign ys = (y_r + swc_pkg::CORDIC_W'(swc_pkg::CORDIC_RND)) >>> swc_pkg::CORDIC_DROP;
  assign xc = clamp_q14(xs);
  assign yc = clamp_q14(ys);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= !req.start && !busy_r && fin_r;
      if (req.start) begin
        busy_r <= 1'b1;
        fin_r  <= 1'b0;
        i_r    <= '0;
        flip_r <= flip_in;
        x_r    <= swc_pkg::CORDIC_W'(swc_pkg::CORDIC_GAIN);
        y_r    <= '0;
        z_r    <= z_init;
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        if (i_r == swc_pkg::STEP_W'(swc_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        cos_r  <= flip_r ? -xc : xc;
        sin_r  <= flip_r ? -yc : yc;
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.sin_q = sin_r;
  assign rsp.cos_q = cos_r;

endmodule

`default_nettype wire

/* hdl/swc_mul.sv */
// swc_mul: the one shared signed multiplier, product registered
// depends on swc_pkg
`default_nettype none

module swc_mul (
  input  wire logic                              clk,
  input  wire logic signed [swc_pkg::MUL_W-1:0]  op_a,
  input  wire logic signed [swc_pkg::MUL_W-1:0]  op_b,
  output logic signed [swc_pkg::PROD_W-1:0]      prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

`default_nettype wire

/* hdl/swept_circle_collision.sv */
// swept_circle_collision: top level, sequencer and position datapath of the swept hit test
// depends on swc_pkg, swc_cordic and swc_mul
//
// usage
//   one input transaction (in_valid high, in_stall low) carries both circles, the
//   radii, the mover's speed and heading; exactly one output transaction (out_hit)
//   follows. in_stall stays high from the accepting edge until the result has
//   been written into the output register, so one item is worked on at a time.
// sequence
//   no sweep (speed not above the radius sum, or a zero radius sum): only the current
//   position is tested. sweep: N positions are tested (sub-positions up to a hit, plus
//   the current one if none hits), at most MAX_SUBSTEPS + 1; the run time is set by the
//   14-step cordic and the single multiplier, two squares and a compare per position.
// reset
//   rst_n is synchronous, active low; the sequencer returns to idle and the
//   output register empties.
// stalls
//   the result sits in an output register; a stalled result holds its value, and
//   a finished item waits in its last state until that register is free.
`default_nettype none

module swept_circle_collision (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [swc_pkg::COORD_W-1:0]  in_mover_x,
  input  wire logic signed [swc_pkg::COORD_W-1:0]  in_mover_y,
  input  wire logic signed [swc_pkg::COORD_W-1:0]  in_target_x,
  input  wire logic signed [swc_pkg::COORD_W-1:0]  in_target_y,
  input  wire logic [swc_pkg::LEN_W-1:0]           in_mover_radius,
  input  wire logic [swc_pkg::LEN_W-1:0]           in_target_radius,
  input  wire logic [swc_pkg::LEN_W-1:0]           in_mover_speed,
  input  wire logic [swc_pkg::LEN_W-1:0]           in_heading,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_hit
);

  typedef enum logic [3:0] {
    S_IDLE, S_RR, S_LOAD, S_CORDIC, S_MCS, S_MSS, S_MCR, S_MSR, S_MSTORE,
    S_DX, S_DY, S_CMP, S_DONE
  } state_t;

  state_t state_r;

  // latched transaction
  logic signed [swc_pkg::COORD_W-1:0] mx_r, my_r, tx_r, ty_r;
  logic [swc_pkg::RSUM_W-1:0]         r_r;
  logic [swc_pkg::LEN_W-1:0]          speed_r;
  logic [swc_pkg::PHASE_W-1:0]        phase_r;
  logic                               sweep_r;

  // sweep datapath
  logic [swc_pkg::RR_W-1:0]           rr_r;
  logic signed [swc_pkg::POS_W-1:0]   px_r, py_r, stx_r, sty_r;
  logic [swc_pkg::SQ_W-1:0]           dxsq_r;
  logic [swc_pkg::CNT_W-1:0]          j_r;
  logic [swc_pkg::ACC_W-1:0]          acc_r;
  logic                               final_r, hit_r;
  logic                               out_valid_r, out_hit_r;

  logic [swc_pkg::RSUM_W-1:0]         r_in;
  logic [swc_pkg::PHASE_W-1:0]        phase_in;
  logic signed [swc_pkg::MUL_W-1:0]   op_a, op_b, dx, dy;
  logic signed [swc_pkg::MUL_W-1:0]   r_op, spd_op, cos_op, sin_op;
  logic signed [swc_pkg::PROD_W-1:0]  prod_r, rsum;
  logic signed [swc_pkg::POS_W-1:0]   off;
  logic [swc_pkg::SQ_W:0]             dist_sq;
  logic                               near;
  logic [swc_pkg::ACC_W-1:0]          acc_nxt;
  logic [swc_pkg::CNT_W-1:0]          j_nxt;
  logic                               more;

  swc_pkg::cordic_req_t creq;
  swc_pkg::cordic_rsp_t crsp;

  assign r_in     = swc_pkg::RSUM_W'(in_mover_radius) + swc_pkg::RSUM_W'(in_target_radius);
  // heading bits above the angle width are ignored, phase is a 16-bit turn
  assign phase_in = (swc_pkg::PHASE_W'(in_heading) & swc_pkg::ANGLE_MASK)
                    << (swc_pkg::PHASE_W - swc_pkg::ANGLE_BITS);

  assign creq.start = (state_r == S_LOAD) && sweep_r;
  assign creq.phase = phase_r;

  swc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  // operand select for the shared multiplier
  assign r_op   = $signed(swc_pkg::MUL_W'(r_r));
  assign spd_op = $signed(swc_pkg::MUL_W'(speed_r));
  assign cos_op = swc_pkg::MUL_W'(crsp.cos_q);
  assign sin_op = swc_pkg::MUL_W'(crsp.sin_q);
  assign dx     = swc_pkg::MUL_W'(px_r) - swc_pkg::MUL_W'(tx_r);
  assign dy     = swc_pkg::MUL_W'(py_r) - swc_pkg::MUL_W'(ty_r);

  always_comb begin
    unique case (state_r)
      S_RR:    begin op_a = r_op;   op_b = r_op;   end
      S_MCS:   begin op_a = cos_op; op_b = spd_op; end
      S_MSS:   begin op_a = sin_op; op_b = spd_op; end
      S_MCR:   begin op_a = cos_op; op_b = r_op;   end
      S_MSR:   begin op_a = sin_op; op_b = r_op;   end
      S_DX:    begin op_a = dx;     op_b = dx;     end
      S_DY:    begin op_a = dy;     op_b = dy;     end
      default: begin op_a = '0;     op_b = '0;     end
    endcase
  end

  swc_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Q1.14 times Q.4 back to Q.4, rounded half up
  assign rsum = prod_r + $signed(swc_pkg::PROD_W'(swc_pkg::Q14_HALF));
  assign off  = swc_pkg::POS_W'(rsum >>> swc_pkg::Q14_FRAC);

  // squares are never negative, so the low bits carry the whole value
  assign dist_sq = {1'b0, dxsq_r} + {1'b0, prod_r[swc_pkg::SQ_W-1:0]};
  assign near    = dist_sq < (swc_pkg::SQ_W + 1)'(rr_r);

  // j < ceil(speed/r) is the same as j*r < speed, so no divider is needed
  assign acc_nxt = acc_r + swc_pkg::ACC_W'(r_r);
  assign j_nxt   = j_r + 1'b1;
  assign more    = (j_nxt < swc_pkg::CNT_W'(swc_pkg::MAX_SUBSTEPS))
                   && (acc_nxt < swc_pkg::ACC_W'(speed_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      // a new result in S_DONE takes over the output register itself
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mx_r    <= in_mover_x;
            my_r    <= in_mover_y;
            tx_r    <= in_target_x;
            ty_r    <= in_target_y;
            r_r     <= r_in;
            speed_r <= in_mover_speed;
            phase_r <= phase_in;
            sweep_r <= (r_in != '0) && (swc_pkg::RSUM_W'(in_mover_speed) > r_in);
            hit_r   <= 1'b0;
            state_r <= S_RR;
          end
        end
        S_RR: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          rr_r <= prod_r[swc_pkg::RR_W-1:0];
          if (sweep_r) begin
            state_r <= S_CORDIC;
          end else begin
            // no sweep: only the current position is tested
            px_r    <= swc_pkg::POS_W'(mx_r);
            py_r    <= swc_pkg::POS_W'(my_r);
            final_r <= 1'b1;
            state_r <= S_DX;
          end
        end
        S_CORDIC: begin
          if (crsp.done) begin
            state_r <= S_MCS;
          end
        end
        S_MCS: begin
          state_r <= S_MSS;
        end
        S_MSS: begin
          // step back one frame along the heading
          px_r    <= swc_pkg::POS_W'(mx_r) - off;
          state_r <= S_MCR;
        end
        S_MCR: begin
          py_r    <= swc_pkg::POS_W'(my_r) - off;
          state_r <= S_MSR;
        end
        S_MSR: begin
          stx_r   <= off;
          state_r <= S_MSTORE;
        end
        S_MSTORE: begin
          sty_r   <= off;
          j_r     <= '0;
          acc_r   <= '0;
          final_r <= 1'b0;
          state_r <= S_DX;
        end
        S_DX: begin
          state_r <= S_DY;
        end
        S_DY: begin
          dxsq_r  <= prod_r[swc_pkg::SQ_W-1:0];
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (near) begin
            hit_r   <= 1'b1;
            state_r <= S_DONE;
          end else if (final_r) begin
            state_r <= S_DONE;
          end else if (more) begin
            px_r    <= px_r + stx_r;
            py_r    <= py_r + sty_r;
            j_r     <= j_nxt;
            acc_r   <= acc_nxt;
            state_r <= S_DX;
          end else begin
            // sweep over, test the current position last
            j_r     <= j_nxt;
            px_r    <= swc_pkg::POS_W'(mx_r);
            py_r    <= swc_pkg::POS_W'(my_r);
            final_r <= 1'b1;
            state_r <= S_DX;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= hit_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

`ifndef SYNTH
  // an accepted transaction always starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RR))
    else $error("accepted transaction did not start the sequencer");

  // the cordic only finishes while the sequencer waits for it
  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    crsp.done |-> (state_r == S_CORDIC))
    else $error("cordic result arrived outside its wait state");

  // sub-position count never passes its limit
  a_substep_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && !final_r) |-> (j_r < swc_pkg::CNT_W'(swc_pkg::MAX_SUBSTEPS)))
    else $error("sub-position count passed its limit");

  // sweep positions are only tested when a sweep was decided
  a_sweep_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DX && !final_r) |-> sweep_r)
    else $error("sweep position tested without a sweep");

  // a zero radius sum can never report a hit
  a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && r_r == '0) |-> !hit_r)
    else $error("hit reported with zero radius sum");
`endif

endmodule

`default_nettype wire

/* tb/swept_circle_collision_tb.sv */
// swept_circle_collision_tb: self-checking bench for the swept circle hit test
// depends on swc_pkg and swept_circle_collision; a short table of directed transactions
// comes first, and a local cordic and sweep predictor checks each hit not typed into it
`timescale 1ns / 1ps

module swept_circle_collision_tb;

  localparam int N_ITEMS     = 700;
  localparam int CYCLE_LIMIT = 1_000_000;
  // extra watch time for stray results after the drain
  localparam int TAIL_CYCLES = 300;
  // both sides run without idling while the accepted count is from QUIET_FROM up to below QUIET_TO
  localparam int QUIET_FROM  = 300;
  localparam int QUIET_TO    = 420;
  localparam int IDLE_PCT    = 15;
  localparam int SUBSTEP_CAP = swc_pkg::MAX_SUBSTEPS;

  typedef struct packed {
    logic signed [swc_pkg::COORD_W-1:0] mx;
    logic signed [swc_pkg::COORD_W-1:0] my;
    logic signed [swc_pkg::COORD_W-1:0] tx;
    logic signed [swc_pkg::COORD_W-1:0] ty;
    logic [swc_pkg::LEN_W-1:0]          mr;
    logic [swc_pkg::LEN_W-1:0]          tr;
    logic [swc_pkg::LEN_W-1:0]          spd;
    logic [swc_pkg::LEN_W-1:0]          hd;
    bit                                 known;  // hit is typed into the table
    bit                                 hit;    // expected hit once accepted
  } collide_item_t;

  typedef struct packed {
    longint sin_v;
    longint cos_v;
  } trig_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [swc_pkg::COORD_W-1:0] in_mover_x;
  logic signed [swc_pkg::COORD_W-1:0] in_mover_y;
  logic signed [swc_pkg::COORD_W-1:0] in_target_x;
  logic signed [swc_pkg::COORD_W-1:0] in_target_y;
  logic [swc_pkg::LEN_W-1:0] in_mover_radius;
  logic [swc_pkg::LEN_W-1:0] in_target_radius;
  logic [swc_pkg::LEN_W-1:0] in_mover_speed;
  logic [swc_pkg::LEN_W-1:0] in_heading;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;

  collide_item_t directed_rows[$];
  collide_item_t pending_hits[$];   // accepted transactions waiting for their result
  collide_item_t cur_item;
  int n_accepted = 0;
  int n_mismatch = 0;
  int n_cycles   = 0;

  // arctangent of 2^-i in 16-bit phase units
  int atan_units [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  wire quiet = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);

  swept_circle_collision dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mover_x       (in_mover_x),
    .in_mover_y       (in_mover_y),
    .in_target_x      (in_target_x),
    .in_target_y      (in_target_y),
    .in_mover_radius  (in_mover_radius),
    .in_target_radius (in_target_radius),
    .in_mover_speed   (in_mover_speed),
    .in_heading       (in_heading),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sine and cosine of the heading in Q1.14: 14 rotations at Q.16, then rounded
  // half up and clamped; the 2nd and 3rd quadrants are folded onto the 1st and 4th by a sign flip
  function automatic trig_t heading_trig(input logic [swc_pkg::LEN_W-1:0] hd);
    longint x, y, z, dx, dy;
    logic [15:0] ph;
    bit flip;
    trig_t t;
    ph = 16'(hd & ((1 << swc_pkg::ANGLE_BITS) - 1)) << (16 - swc_pkg::ANGLE_BITS);
    x = 39797;
    y = 0;
    z = ph;
    flip = 1'b0;
    if (ph >= 16384 && ph < 49152) begin
      flip = 1'b1;
      z = z - 32768;
    end else if (ph >= 49152) begin
      z = z - 65536;
    end
    for (int i = 0; i < 14; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_units[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_units[i];
      end
    end
    x = (x + 2) >>> 2;
    y = (y + 2) >>> 2;
    if (x > 16384) x = 16384;
    if (x < -16384) x = -16384;
    if (y > 16384) y = 16384;
    if (y < -16384) y = -16384;
    if (flip) begin
      x = -x;
      y = -y;
    end
    t.sin_v = y;
    t.cos_v = x;
    return t;
  endfunction

  // Q1.14 times Q.4, rounded half up back to Q.4
  function automatic longint q14_scale(input longint a, input longint b);
    return (a * b + 8192) >>> 14;
  endfunction

  function automatic bit within_reach(input longint px, input longint py,
                                      input longint tx, input longint ty,
                                      input longint r);
    return (px - tx) * (px - tx) + (py - ty) * (py - ty) < r * r;
  endfunction

  // step back one frame, walk the path in radius-sum strides, then the current spot
  function automatic bit sweep_hit(input collide_item_t it);
    longint mx, my, tx, ty, r, spd, px, py, stx, sty, cnt;
    trig_t t;
    bit hit;
    mx = it.mx;
    my = it.my;
    tx = it.tx;
    ty = it.ty;
    r = longint'(it.mr) + longint'(it.tr);
    spd = it.spd;
    hit = 1'b0;
    if (r > 0 && spd > r) begin
      t = heading_trig(it.hd);
      px = mx - q14_scale(t.cos_v, spd);
      py = my - q14_scale(t.sin_v, spd);
      stx = q14_scale(t.cos_v, r);
      sty = q14_scale(t.sin_v, r);
      cnt = (spd + r - 1) / r;
      if (cnt > SUBSTEP_CAP) cnt = SUBSTEP_CAP;
      for (longint j = 0; j < cnt && !hit; j++) begin
        if (within_reach(px, py, tx, ty, r)) hit = 1'b1;
        px = px + stx;
        py = py + sty;
      end
    end
    if (!hit && within_reach(mx, my, tx, ty, r)) hit = 1'b1;
    return hit;
  endfunction

  task automatic add_row(input int mx, input int my, input int tx, input int ty,
                         input int mr, input int tr, input int spd, input int hd,
                         input bit known, input bit hit);
    collide_item_t it;
    it.mx = 16'(mx);
    it.my = 16'(my);
    it.tx = 16'(tx);
    it.ty = 16'(ty);
    it.mr = 12'(mr);
    it.tr = 12'(tr);
    it.spd = 12'(spd);
    it.hd = 12'(hd);
    it.known = known;
    it.hit = hit;
    directed_rows.push_back(it);
  endtask

  // random transactions: mostly targets placed near the swept path, plus tight
  // clusters and fully random fields
  function automatic collide_item_t rand_item();
    collide_item_t it;
    trig_t t;
    int pick, r, d, back, mx, my;
    it.known = 1'b0;
    it.hit = 1'b0;
    it.hd = 12'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) begin
      it.mx = 16'($urandom);
      it.my = 16'($urandom);
      it.tx = 16'($urandom);
      it.ty = 16'($urandom);
      it.mr = 12'($urandom);
      it.tr = 12'($urandom);
      it.spd = 12'($urandom);
    end else if (pick < 35) begin
      it.mr = 12'($urandom_range(15));
      it.tr = 12'($urandom_range(15));
      it.spd = 12'($urandom_range(63));
      it.mx = 16'($urandom);
      it.my = 16'($urandom);
      it.tx = 16'(int'(it.mx) + int'($urandom_range(128)) - 64);
      it.ty = 16'(int'(it.my) + int'($urandom_range(128)) - 64);
    end else begin
      // one radius is zero now and then
      it.mr = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(300, 1));
      it.tr = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(300, 1));
      if (it.mr == 0 && it.tr == 0) it.tr = 12'd1;
      r = int'(it.mr) + int'(it.tr);
      // mostly a few sub-steps, sometimes enough to saturate the count
      if ($urandom_range(7) == 0)
        it.spd = 12'($urandom_range(4095, r + 1));
      else
        it.spd = 12'($urandom_range(6 * r, r + 1));
      mx = int'($urandom_range(40000)) - 20000;
      my = int'($urandom_range(40000)) - 20000;
      it.mx = 16'(mx);
      it.my = 16'(my);
      t = heading_trig(it.hd);
      back = $urandom_range(int'(it.spd));
      d = r + r / 4 + 2;
      it.tx = 16'(mx - int'(q14_scale(t.cos_v, back)) + int'($urandom_range(2 * d)) - d);
      it.ty = 16'(my - int'(q14_scale(t.sin_v, back)) + int'($urandom_range(2 * d)) - d);
    end
    return it;
  endfunction

  // result side: check each output transaction, then pick the next stall
  always @(posedge clk) begin
    collide_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_hits.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual hit=%0b",
                   $time, out_hit);
          n_mismatch++;
        end else begin
          want = pending_hits.pop_front();
          if (out_hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b (m %0d,%0d t %0d,%0d r %0d+%0d v %0d a %0d)",
                     $time, want.hit, out_hit, want.mx, want.my, want.tx, want.ty,
                     want.mr, want.tr, want.spd, want.hd);
            n_mismatch++;
          end
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("swept_circle_collision_tb: errors");
      $finish;
    end
  end

  initial begin
    bit accepted;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mover_x = '0;
    in_mover_y = '0;
    in_target_x = '0;
    in_target_y = '0;
    in_mover_radius = '0;
    in_target_radius = '0;
    in_mover_speed = '0;
    in_heading = '0;

    // zero radius sum: never a hit, even on top of the target
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0);
    add_row(100, -50, 100, -50, 0, 0, 4095, 1234, 1, 0);
    add_row(500, 500, 500, 500, 0, 0, 0, 0, 1, 0);
    // current position only
    add_row(0, 0, 0, 0, 1, 0, 0, 0, 1, 1);
    add_row(-32768, -32768, 32767, 32767, 4095, 4095, 0, 0, 1, 0);
    add_row(32767, 32767, -32768, -32768, 4095, 4095, 4095, 4095, 1, 0);
    add_row(-32768, 32767, -32768, 32767, 4095, 4095, 4095, 2048, 1, 1);
    add_row(0, 0, 0, 0, 4095, 4095, 4095, 0, 1, 1);
    // speed equal to the radius sum: no sweep, and touching is not a hit
    add_row(0, 0, -40, 0, 20, 20, 40, 0, 1, 0);
    // speed just above the radius sum, target at the step-back point
    add_row(0, 0, -41, 0, 20, 20, 41, 0, 0, 0);
    // cardinal and odd headings
    add_row(0, 0, 0, -80, 0, 40, 80, 1024, 0, 0);
    add_row(0, 0, 80, 0, 40, 0, 80, 2048, 0, 0);
    add_row(0, 0, 0, 80, 30, 10, 80, 3072, 0, 0);
    add_row(0, 0, -60, -60, 10, 10, 85, 512, 0, 0);
    add_row(0, 0, -100, 1, 50, 0, 100, 4095, 0, 0);
    add_row(0, 0, 100, 0, 25, 25, 120, 2047, 0, 0);
    add_row(1000, -1000, 1200, -1000, 3, 3, 4095, 1365, 0, 0);
    add_row(0, 0, -200, 0, 0, 5, 200, 0, 0, 0);
    // sub-step count saturates: inside and past the tested stretch
    add_row(0, 0, -4050, 0, 1, 0, 4095, 0, 0, 0);
    add_row(0, 0, -3900, 0, 1, 0, 4095, 0, 0, 0);
    // sweeps starting at the coordinate extremes
    add_row(-32768, -32768, -28700, -32768, 2, 2, 4095, 2048, 0, 0);
    add_row(32767, 32767, 28672, 32767, 2, 2, 4095, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // input side: one transaction in flight; a stalled payload is held
    while (n_accepted < N_ITEMS || in_valid) begin
      @(posedge clk);
      accepted = in_valid && !in_stall;
      if (accepted) begin
        if (!cur_item.known) cur_item.hit = sweep_hit(cur_item);
        pending_hits.push_back(cur_item);
        n_accepted++;
      end
      if (!in_valid || accepted) begin
        if (n_accepted < N_ITEMS && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          cur_item = (n_accepted < directed_rows.size()) ? directed_rows[n_accepted]
                                                         : rand_item();
          in_mover_x <= cur_item.mx;
          in_mover_y <= cur_item.my;
          in_target_x <= cur_item.tx;
          in_target_y <= cur_item.ty;
          in_mover_radius <= cur_item.mr;
          in_target_radius <= cur_item.tr;
          in_mover_speed <= cur_item.spd;
          in_heading <= cur_item.hd;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end

    // drain, then watch for stray results
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && pending_hits.size() == 0) begin
      $display("swept_circle_collision_tb: clean");
    end else begin
      $display("swept_circle_collision_tb: errors");
    end
    $finish;
  end

endmodule
